>>> src/tslnf_pkg.sv
// shared types, character codes and helpers for the line number formatter
package tslnf_pkg;

	localparam int NUMBER_DIGITS_DEF = 6;
	localparam int CFG_IDX_W = 3;
	localparam int PH_COUNT = 7;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
	} tslnf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} tslnf_out_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUMBER_NONBLANK  = 3'd0,
		REG_NUMBER_ALL       = 3'd1,
		REG_SQUEEZE_BLANK    = 3'd2,
		REG_MARK_LINE_END    = 3'd3,
		REG_SHOW_TABS        = 3'd4,
		REG_SHOW_NONPRINTING = 3'd5
	} tslnf_reg_t;

	// output segments in the order they are sent
	typedef enum logic [2:0] {
		PH_NUM1   = 3'd0,
		PH_PREFIX = 3'd1,
		PH_J      = 3'd2,
		PH_NUM2   = 3'd3,
		PH_PAD    = 3'd4,
		PH_DOLLAR = 3'd5,
		PH_CHAR   = 3'd6
	} tslnf_phase_t;

	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NL        = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DOLLAR    = 8'h24;
	localparam logic [7:0] CH_DASH      = 8'h2D;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_QMARK     = 8'h3F;
	localparam logic [7:0] CH_I         = 8'h49;
	localparam logic [7:0] CH_J         = 8'h4A;
	localparam logic [7:0] CH_M         = 8'h4D;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_DEL       = 8'h7F;
	localparam logic [7:0] CTRL_END     = 8'd32;
	localparam logic [7:0] CARET_OFFSET = 8'd64;
	localparam logic [7:0] HI_FIRST     = 8'd128;
	localparam logic [7:0] HI_LAST      = 8'd159;
	localparam logic [7:0] M_HAT_J_CODE = 8'd138;

	// lowest enabled segment at or above lo, PH_COUNT when there is none
	function automatic logic [3:0] first_from(input logic [PH_COUNT-1:0] en,
			input logic [3:0] lo);
		logic [3:0] res;
		res = 4'(PH_COUNT);
		for (int i = PH_COUNT - 1; i >= 0; i--) begin
			if (en[i] && (4'(i) >= lo)) begin
				res = 4'(i);
			end
		end
		return res;
	endfunction

endpackage

>>> src/text_stream_line_number_formatter_top.sv
// line numbering and non-printing display formatter, one input byte to many output bytes
//
//  channel | signals                                  | moves
//  --------+------------------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_data              | one raw byte, file start flag
//  out     | out_valid, out_ready, out_data           | one formatted byte, last flag
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| one mode bit per transaction
//
// an item occupies the byte sequencer until all n bytes it causes are sent (n = 1 to 18 for six digits);
// the single output register sends one byte per cycle unless out_ready stalls it
// a dropped (squeezed) newline is accepted and gives no output
// out_ready low holds the output register and the sequencer; in_ready follows within the cycle
// after reset the block is ready at once, no clearing pass
module text_stream_line_number_formatter_top #(
	parameter int NUMBER_DIGITS = tslnf_pkg::NUMBER_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tslnf_pkg::tslnf_in_t              in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tslnf_pkg::tslnf_out_t             out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tslnf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                              cfg_data
);
	import tslnf_pkg::*;

	localparam int BCD_W = 4 * NUMBER_DIGITS;
	localparam int IDX_W = ($clog2(NUMBER_DIGITS + 1) > 2) ? $clog2(NUMBER_DIGITS + 1) : 2;
	localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

	// bcd +1, holds at all nines
	function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] res;
		logic             carry;
		res = v;
		carry = 1'b1;
		for (int k = 0; k < NUMBER_DIGITS; k++) begin
			if (carry) begin
				if (v[4*k +: 4] == 4'd9) begin
					res[4*k +: 4] = 4'd0;
				end else begin
					res[4*k +: 4] = v[4*k +: 4] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		return carry ? v : res;
	endfunction

	// mode registers
	logic number_nonblank_q, number_all_q, squeeze_blank_q;
	logic mark_line_end_q, show_tabs_q, show_nonprinting_q;

	// stream state
	logic [BCD_W-1:0] line_count_q;
	logic [1:0]       newline_run_q;
	logic             at_line_start_q;

	// plan of the item being sent
	logic                plan_valid_s1;
	logic [PH_COUNT-1:0] en_s1;
	logic                prefix_long_s1;
	logic [7:0]          ch_s1;
	logic [BCD_W-1:0]    num1_s1, num2_s1;
	tslnf_phase_t        phase_q, phase_d;
	logic [IDX_W-1:0]    idx_q, idx_d;

	// output register
	logic       out_valid_s2;
	tslnf_out_t out_data_s2;

	// decode of the incoming byte
	logic [7:0]          ch, ch2;
	logic [BCD_W-1:0]    lc_eff, lc_a, n2, lc_new;
	logic [1:0]          run_eff, run_inc, run_new;
	logic                als_eff, als1, als_new;
	logic                is_nl, drop, numbering, n1;
	logic                tab_shown, ctrl, del, hi, jq;
	logic [PH_COUNT-1:0] en_d;
	logic [3:0]          first_d;

	// sequencer
	logic       accept, load, out_adv, emit, seg_end, emit_last;
	logic [3:0] nxt;
	logic [7:0] byte_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_nonblank_q  <= 1'b0;
			number_all_q       <= 1'b0;
			squeeze_blank_q    <= 1'b0;
			mark_line_end_q    <= 1'b0;
			show_tabs_q        <= 1'b0;
			show_nonprinting_q <= 1'b0;
		end else if (cfg_valid) begin
			case (tslnf_reg_t'(cfg_index))
				REG_NUMBER_NONBLANK:  number_nonblank_q  <= cfg_data;
				REG_NUMBER_ALL:       number_all_q       <= cfg_data;
				REG_SQUEEZE_BLANK:    squeeze_blank_q    <= cfg_data;
				REG_MARK_LINE_END:    mark_line_end_q    <= cfg_data;
				REG_SHOW_TABS:        show_tabs_q        <= cfg_data;
				REG_SHOW_NONPRINTING: show_nonprinting_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ch        = in_data.in_byte;
		lc_eff    = in_data.file_start ? BCD_ONE : line_count_q;
		run_eff   = in_data.file_start ? 2'd0 : newline_run_q;
		als_eff   = in_data.file_start | at_line_start_q;
		is_nl     = (ch == CH_NL);
		run_inc   = (run_eff == 2'd3) ? 2'd3 : run_eff + 2'd1;
		drop      = squeeze_blank_q && is_nl && (run_eff >= 2'd2);
		run_new   = squeeze_blank_q ? (is_nl ? run_inc : 2'd0) : run_eff;
		numbering = number_all_q | number_nonblank_q;
		n1        = als_eff && (number_all_q || (number_nonblank_q && !is_nl));
		als1      = als_eff && !n1;
		tab_shown = show_tabs_q && (ch == CH_TAB);
		ctrl      = show_nonprinting_q && (ch < CTRL_END) && !is_nl && (ch != CH_TAB);
		del       = show_nonprinting_q && (ch == CH_DEL);
		hi        = show_nonprinting_q && (ch inside {[HI_FIRST:HI_LAST]});
		ch2 = ch;
		if (tab_shown) begin
			ch2 = CH_I;
		end else if (ctrl) begin
			ch2 = ch + CARET_OFFSET;
		end else if (del) begin
			ch2 = CH_QMARK;
		end else if (hi) begin
			ch2 = ch - CARET_OFFSET;
		end
		// M-^J quirk: J, then a fresh number instead of the byte
		jq      = hi && (ch == M_HAT_J_CODE) && numbering;
		als_new = is_nl | als1;
		lc_a    = bcd_inc(lc_eff);
		n2      = n1 ? lc_a : lc_eff;
		lc_new  = jq ? bcd_inc(n2) : n2;
		en_d = '0;
		en_d[PH_NUM1]   = n1;
		en_d[PH_PREFIX] = tab_shown | ctrl | del | hi;
		en_d[PH_J]      = jq;
		en_d[PH_NUM2]   = jq;
		en_d[PH_PAD]    = mark_line_end_q && is_nl && als1 && numbering;
		en_d[PH_DOLLAR] = mark_line_end_q && is_nl;
		en_d[PH_CHAR]   = !jq;
		first_d = first_from(en_d, 4'd0);
	end

	assign out_adv  = !out_valid_s2 || out_ready;
	assign emit     = plan_valid_s1 && out_adv;
	assign in_ready = !plan_valid_s1 || (out_adv && emit_last);
	assign accept   = in_valid && in_ready;
	assign load     = accept && !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q    <= BCD_ONE;
			newline_run_q   <= 2'd0;
			at_line_start_q <= 1'b1;
		end else if (accept) begin
			newline_run_q <= run_new;
			if (drop) begin
				line_count_q    <= lc_eff;
				at_line_start_q <= als_eff;
			end else begin
				line_count_q    <= lc_new;
				at_line_start_q <= als_new;
			end
		end
	end

	// segment bookkeeping
	always_comb begin
		case (phase_q)
			PH_NUM1, PH_NUM2, PH_PAD: seg_end = (idx_q == IDX_W'(NUMBER_DIGITS));
			PH_PREFIX:                seg_end = prefix_long_s1 ? (idx_q == IDX_W'(2))
			                                                   : (idx_q == '0);
			default:                  seg_end = 1'b1;
		endcase
		nxt       = first_from(en_s1, {1'b0, phase_q} + 4'd1);
		emit_last = seg_end && (nxt == 4'(PH_COUNT));
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		if (load) begin
			phase_d = tslnf_phase_t'(first_d[2:0]);
			idx_d   = '0;
		end else if (emit) begin
			if (!seg_end) begin
				idx_d = idx_q + IDX_W'(1);
			end else if (!emit_last) begin
				phase_d = tslnf_phase_t'(nxt[2:0]);
				idx_d   = '0;
			end
		end
	end

	// output byte of the current step
	logic [BCD_W-1:0]         numsel;
	logic [NUMBER_DIGITS-1:0] zero_from;
	logic                     zf, dblank;
	logic [3:0]               dsel;
	logic [7:0]               num_byte;

	always_comb begin
		numsel = (phase_q == PH_NUM2) ? num2_s1 : num1_s1;
		zf = 1'b1;
		for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
			zf = zf & (numsel[4*k +: 4] == 4'd0);
			zero_from[k] = zf;
		end
		dsel   = 4'd0;
		dblank = 1'b0;
		for (int k = 0; k < NUMBER_DIGITS; k++) begin
			if (idx_q == IDX_W'(NUMBER_DIGITS - 1 - k)) begin
				dsel   = numsel[4*k +: 4];
				dblank = (k != 0) && zero_from[k];
			end
		end
		if (idx_q == IDX_W'(NUMBER_DIGITS)) begin
			num_byte = CH_TAB;
		end else if (dblank) begin
			num_byte = CH_SPACE;
		end else begin
			num_byte = CH_ZERO + {4'd0, dsel};
		end
		case (phase_q)
			PH_NUM1, PH_NUM2: byte_d = num_byte;
			PH_PREFIX: begin
				if (prefix_long_s1 && (idx_q == '0)) begin
					byte_d = CH_M;
				end else if (prefix_long_s1 && (idx_q == IDX_W'(1))) begin
					byte_d = CH_DASH;
				end else begin
					byte_d = CH_CARET;
				end
			end
			PH_J:      byte_d = CH_J;
			PH_PAD:    byte_d = (idx_q == IDX_W'(NUMBER_DIGITS)) ? CH_TAB : CH_SPACE;
			PH_DOLLAR: byte_d = CH_DOLLAR;
			default:   byte_d = ch_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_valid_s1 <= 1'b0;
			phase_q       <= PH_CHAR;
			idx_q         <= '0;
			out_valid_s2  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			if (load) begin
				plan_valid_s1 <= 1'b1;
			end else if (emit && emit_last) begin
				plan_valid_s1 <= 1'b0;
			end
			if (out_adv) begin
				out_valid_s2 <= plan_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			en_s1          <= en_d;
			prefix_long_s1 <= hi;
			ch_s1          <= ch2;
			num1_s1        <= lc_eff;
			num2_s1        <= n2;
		end
		if (emit) begin
			out_data_s2.out_byte <= byte_d;
			out_data_s2.last     <= emit_last;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

endmodule

>>> src/tslnf_checker.sv
// port-level checks for the line number formatter, bound to the top level
module tslnf_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input tslnf_pkg::tslnf_out_t out_data
);
	import tslnf_pkg::*;

	// a stalled output transaction keeps its byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// bytes of one item follow without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid)
		else $error("gap inside an item's output");

	// output only starts once an accepted input has passed the plan register and the output register
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output without an accepted input");

	// input is only held off while output is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("input held off with nothing to send");

endmodule

bind text_stream_line_number_formatter_top tslnf_checker u_tslnf_checker (.*);
